[hdl/block_bitmap_allocator_defines.svh]
// Assertion macros for the block bitmap allocator.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BBA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bba assertion failed");
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba assertion failed");
`else
`define BBA_ASSERT_NEVER(lbl, cond)
`define BBA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  // Bitmap geometry
  localparam int MAX_BLOCKS = 8192;
  localparam int MAP_BYTES  = MAX_BLOCKS / 8;
  localparam int ROW_BYTES  = 16;
  localparam int ROW_W      = ROW_BYTES * 8;
  localparam int ROWS       = MAP_BYTES / ROW_BYTES;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int BYTE_AW    = $clog2(ROW_BYTES);
  localparam int BIT_AW     = $clog2(ROW_W);
  localparam int MAPB_AW    = $clog2(MAP_BYTES);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int IDX_W  = 13;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 14;
  localparam int LIM_W  = 14;
  localparam int NB_W   = LIM_W - 3;
  localparam int RC_W   = ROW_AW + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(MAX_BLOCKS);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture request fields, rewind scan pointer
    logic scan;      // issue next scan row, evaluate returned row
    logic rd_idx;    // read the row holding slot_index
    logic rmw;       // modify and write back the row of slot_index
    logic clr;       // empty bitmap and count
    logic load_out;  // move result into output registers
  } bba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
  } bba_stat_t;

endpackage

`default_nettype wire

[hdl/bba_ctrl.sv]
`default_nettype none

module bba_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [bba_pkg::REQ_W-1:0]  in_req_type,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire bba_pkg::bba_stat_t         st,
  output bba_pkg::bba_cmd_t               cmd
);
  import bba_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  // Sequence one request at a time
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.latch    = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_req_type) inside
            REQ_ALLOC:           state_nxt = S_SCAN;
            REQ_MARK, REQ_FREE:  state_nxt = S_RD;
            default:             state_nxt = S_CLR;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_hit || st.scan_miss) state_nxt = S_DONE;
      end
      S_RD: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.rmw   = 1'b1;
        state_nxt = S_DONE;
      end
      S_CLR: begin
        cmd.clr   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/bba_datapath.sv]
`default_nettype none

module bba_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bba_pkg::LIM_W-1:0]   cfg_wr_data,
  input  wire logic [bba_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [bba_pkg::IDX_W-1:0]   in_slot_index,
  input  wire bba_pkg::bba_cmd_t           cmd,
  output bba_pkg::bba_stat_t               st,
  output logic [bba_pkg::IDX_W-1:0]        out_granted_index,
  output logic [bba_pkg::STAT_W-1:0]       out_status,
  output logic [bba_pkg::CNT_W-1:0]        out_used_total
);
  import bba_pkg::*;

  // Bitmap rows, valid bits stand in for reset contents
  logic [ROW_W-1:0]  mem [0:ROWS-1];
  logic [ROWS-1:0]   row_valid_r;

  logic [LIM_W-1:0]  tracked_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [REQ_W-1:0]  req_r;
  logic [IDX_W-1:0]  idx_r;
  logic [RC_W-1:0]   scan_row_r;
  logic              rd_pend_r;
  logic [ROW_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [ROW_AW-1:0] rd_row_r;
  logic [IDX_W-1:0]  res_granted_r, res_granted_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  out_granted_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CNT_W-1:0]  out_used_r;

  logic [LIM_W-1:0]  limit;
  logic [NB_W-1:0]   nbytes;
  logic [RC_W-1:0]   row_cnt;
  logic              scan_issue;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_addr;
  logic [ROW_W-1:0]  row_eff;
  logic              hit_any;
  logic [BYTE_AW-1:0] hit_byte;
  logic [7:0]        sel_byte;
  logic [2:0]        hit_pos;
  logic [BIT_AW-1:0] scan_bit;
  logic [BIT_AW-1:0] idx_bit;
  logic              range_err;
  logic              wr_en;
  logic [ROW_AW-1:0] wr_addr;
  logic [ROW_W-1:0]  wr_data;

  // Effective limit and scan extent
  assign limit   = (tracked_r > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : tracked_r;
  assign nbytes  = limit[LIM_W-1:3];
  assign row_cnt = RC_W'((NB_W'(nbytes) + NB_W'(ROW_BYTES - 1)) >> BYTE_AW);

  assign scan_issue = cmd.scan && (scan_row_r < row_cnt);
  assign rd_en      = scan_issue || cmd.rd_idx;
  assign rd_addr    = cmd.rd_idx ? idx_r[IDX_W-1 -: ROW_AW] : scan_row_r[ROW_AW-1:0];

  assign row_eff = rd_vld_r ? rd_data_r : '0;

  // Pick first byte in scan range with a free bit
  always_comb begin
    hit_any  = 1'b0;
    hit_byte = '0;
    for (int b = ROW_BYTES - 1; b >= 0; b--) begin
      if ((NB_W'({rd_row_r, BYTE_AW'(b)}) < nbytes) && (row_eff[b*8 +: 8] != 8'hFF)) begin
        hit_any  = 1'b1;
        hit_byte = BYTE_AW'(b);
      end
    end
  end

  assign sel_byte = row_eff[{hit_byte, 3'b000} +: 8];

  // Lowest clear bit position in that byte
  always_comb begin
    hit_pos = '0;
    for (int p = 7; p >= 0; p--) begin
      if (!sel_byte[p]) hit_pos = 3'(p);
    end
  end

  assign scan_bit  = {hit_byte, hit_pos};
  assign idx_bit   = {idx_r[BYTE_AW+2:3], ~idx_r[2:0]};
  assign range_err = ({1'b0, idx_r} >= limit);

  assign st.scan_hit  = rd_pend_r && hit_any;
  assign st.scan_miss = !rd_pend_r && (scan_row_r >= row_cnt);

  // Row write-back, count and result
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = rd_row_r;
    wr_data         = row_eff;
    count_nxt       = count_r;
    res_granted_nxt = res_granted_r;
    res_status_nxt  = res_status_r;
    if (cmd.scan && st.scan_hit) begin
      wr_en             = 1'b1;
      wr_data[scan_bit] = 1'b1;
      if (count_r != COUNT_MAX) count_nxt = count_r + 1'b1;
      res_granted_nxt   = {rd_row_r, hit_byte, ~hit_pos};
      res_status_nxt    = STAT_OK;
    end
    if (cmd.scan && st.scan_miss) begin
      res_granted_nxt = '0;
      res_status_nxt  = STAT_FULL;
    end
    if (cmd.rmw) begin
      res_granted_nxt = '0;
      res_status_nxt  = range_err ? STAT_RANGE : STAT_OK;
      if (!range_err) begin
        wr_en            = 1'b1;
        wr_addr          = idx_r[IDX_W-1 -: ROW_AW];
        wr_data[idx_bit] = (req_r == REQ_MARK);
        if ((req_r == REQ_FREE) && row_eff[idx_bit] && (count_r != '0)) begin
          count_nxt = count_r - 1'b1;
        end
      end
    end
    if (cmd.clr) begin
      count_nxt       = '0;
      res_granted_nxt = '0;
      res_status_nxt  = STAT_OK;
    end
  end

  // Bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_valid_r[rd_addr];
      rd_row_r  <= rd_addr;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      tracked_r   <= LIMIT_RESET;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      scan_row_r  <= '0;
    end else begin
      if (cmd.clr) row_valid_r <= '0;
      else if (wr_en) row_valid_r[wr_addr] <= 1'b1;
      if (cfg_wr_en) tracked_r <= cfg_wr_data;
      count_r   <= count_nxt;
      rd_pend_r <= scan_issue;
      if (cmd.latch) scan_row_r <= '0;
      else if (scan_issue) scan_row_r <= scan_row_r + 1'b1;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type;
      idx_r <= in_slot_index;
    end
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    if (cmd.load_out) begin
      out_granted_r <= res_granted_r;
      out_status_r  <= res_status_r;
      out_used_r    <= count_r;
    end
  end

  assign out_granted_index = out_granted_r;
  assign out_status        = out_status_r;
  assign out_used_total    = out_used_r;

endmodule

`default_nettype wire

[hdl/block_bitmap_allocator.sv]
// Channel   Ports                                        Beat moves on
// -------   -------------------------------------------  ---------------------
// in        in_req_type, in_slot_index                   in_valid & in_ready
// out       out_granted_index, out_status, out_used_total out_valid & out_ready
// cfg       cfg_wr_data (tracked_blocks)                 cfg_wr_en
//
// One request at a time; the row memory has one read and one write port.
// Allocate reads one 16-byte row per cycle and stops at the first row with a
// free bit in range or after the last row; a limit below 8 scans no row.
// Mark used and free read the row, then write it back; clear all empties the map.
// Reset clears the row valid bits at once, so there is no clearing pass.
// A finished beat waits in the output register while the next request is taken.
`default_nettype none
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bba_pkg::LIM_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bba_pkg::REQ_W-1:0]   in_req_type,
  input  wire logic [bba_pkg::IDX_W-1:0]   in_slot_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bba_pkg::IDX_W-1:0]        out_granted_index,
  output logic [bba_pkg::STAT_W-1:0]       out_status,
  output logic [bba_pkg::CNT_W-1:0]        out_used_total
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t st;

  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .st          (st),
    .cmd         (cmd)
  );

  bba_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_req_type       (in_req_type),
    .in_slot_index     (in_slot_index),
    .cmd               (cmd),
    .st                (st),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .out_used_total    (out_used_total)
  );

  // Only one request in flight
  `BBA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // Scan never reports hit and end of range together
  `BBA_ASSERT_NEVER(a_hit_miss, cmd.scan && st.scan_hit && st.scan_miss)
  // Only a granted allocate carries an index
  `BBA_ASSERT_NEVER(a_grant_zero, out_valid && (out_status != STAT_OK) && (out_granted_index != '0))

endmodule

`default_nettype wire

[bench/block_bitmap_allocator_tb.sv]
// Expected result of one request beat
typedef struct {
  logic [bba_pkg::IDX_W-1:0]  granted;
  logic [bba_pkg::STAT_W-1:0] status;
  logic [bba_pkg::CNT_W-1:0]  used;
} grant_t;

class alloc_scoreboard;
  logic [7:0]                bitmap [bba_pkg::MAP_BYTES];
  logic [bba_pkg::CNT_W-1:0] used_cnt;
  int                        limit_reg;
  int                        errors;
  grant_t                    grant_q [$];

  function new();
    foreach (bitmap[i]) bitmap[i] = '0;
    used_cnt  = '0;
    limit_reg = int'(bba_pkg::LIMIT_RESET);
    errors    = 0;
  endfunction

  function void set_limit(int value);
    limit_reg = value & 16'h3FFF;
  endfunction

  function int pending();
    return grant_q.size();
  endfunction

  // Apply one request to the shadow bitmap and return what the block owes
  function grant_t predict_grant(logic [bba_pkg::REQ_W-1:0] req,
                                 logic [bba_pkg::IDX_W-1:0] idx);
    grant_t     r;
    int         lim;
    int         nbytes;
    int         b;
    int         pos;
    bit         found;
    logic [7:0] freeb;
    lim = (limit_reg > bba_pkg::MAX_BLOCKS) ? bba_pkg::MAX_BLOCKS : limit_reg;
    r.granted = '0;
    r.status  = bba_pkg::STAT_OK;
    case (req)
      bba_pkg::REQ_ALLOC: begin
        // scan whole bytes only; take the lowest clear bit position
        nbytes = lim / 8;
        found  = 1'b0;
        for (b = 0; b < nbytes && !found; b++) begin
          freeb = ~bitmap[b];
          if (freeb != 8'h00) begin
            pos = 0;
            while (!freeb[pos]) pos++;
            bitmap[b][pos] = 1'b1;
            r.granted = bba_pkg::IDX_W'(b * 8 + 7 - pos);
            if (used_cnt != bba_pkg::COUNT_MAX) used_cnt++;
            found = 1'b1;
          end
        end
        if (!found) r.status = bba_pkg::STAT_FULL;
      end
      bba_pkg::REQ_MARK, bba_pkg::REQ_FREE: begin
        if (int'(idx) >= lim) begin
          r.status = bba_pkg::STAT_RANGE;
        end else begin
          b   = int'(idx) / 8;
          pos = 7 - (int'(idx) % 8);
          if (req == bba_pkg::REQ_MARK) begin
            bitmap[b][pos] = 1'b1;
          end else if (bitmap[b][pos]) begin
            bitmap[b][pos] = 1'b0;
            if (used_cnt != '0) used_cnt--;
          end
        end
      end
      default: begin
        foreach (bitmap[i]) bitmap[i] = '0;
        used_cnt = '0;
      end
    endcase
    r.used = used_cnt;
    return r;
  endfunction

  function void note_request(logic [bba_pkg::REQ_W-1:0] req,
                             logic [bba_pkg::IDX_W-1:0] idx);
    grant_q.push_back(predict_grant(req, idx));
  endfunction

  // Compare one result beat against the oldest expectation
  function void check_grant(logic [bba_pkg::IDX_W-1:0]  granted,
                            logic [bba_pkg::STAT_W-1:0] status,
                            logic [bba_pkg::CNT_W-1:0]  used);
    grant_t e;
    if (grant_q.size() == 0) begin
      $display("%0t: result beat with nothing expected: granted %0d status %0d used %0d",
               $time, granted, status, used);
      errors++;
      return;
    end
    e = grant_q.pop_front();
    if (granted !== e.granted) begin
      $display("%0t: granted_index expected %0d actual %0d", $time, e.granted, granted);
      errors++;
    end
    if (status !== e.status) begin
      $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      errors++;
    end
    if (used !== e.used) begin
      $display("%0t: used_total expected %0d actual %0d", $time, e.used, used);
      errors++;
    end
  endfunction
endclass

module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_BEATS  = 130;
  localparam int DRAIN_CYCLES = 100;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [LIM_W-1:0]    cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    in_req_type;
  logic [IDX_W-1:0]    in_slot_index;
  logic                out_valid;
  logic                out_ready;
  logic [IDX_W-1:0]    out_granted_index;
  logic [STAT_W-1:0]   out_status;
  logic [CNT_W-1:0]    out_used_total;

  alloc_scoreboard sb;
  bit              calm;
  int              cur_limit;
  int              phase_limits [10];

  block_bitmap_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_granted_index (out_granted_index),
    .out_status        (out_status),
    .out_used_total    (out_used_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive one request beat; entered and left at a falling edge
  task automatic push_beat(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 12);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_slot_index <= idx;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, idx);
    @(negedge clk);
  endtask

  // Hold off the sender until the block has drained, then write the limit
  task automatic settle_and_config(input int lim);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LIM_W'(lim);
    @(posedge clk);
    sb.set_limit(lim);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = lim;
  endtask

  // Random request, with slot indexes biased toward the allocated region
  task automatic random_beat();
    int               roll;
    int               eff;
    int               win;
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    eff  = (cur_limit > MAX_BLOCKS) ? MAX_BLOCKS : cur_limit;
    win  = (eff > 256) ? 256 : eff;
    roll = $urandom_range(0, 99);
    if (roll < 50)      req = REQ_ALLOC;
    else if (roll < 70) req = REQ_MARK;
    else if (roll < 97) req = REQ_FREE;
    else                req = REQ_CLEAR;
    roll = $urandom_range(0, 9);
    if (roll < 5)      idx = IDX_W'($urandom_range(0, win - 1));
    else if (roll < 8) idx = IDX_W'($urandom_range(0, eff - 1));
    else               idx = IDX_W'($urandom);
    push_beat(req, idx);
  endtask

  // Result side: random back-pressure, check each accepted beat
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_grant(out_granted_index, out_status, out_used_total);
    end
  end

  // Watchdog: count cycles in which no beat moves
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("%0t: watchdog expired", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb            = new();
    calm          = 1'b0;
    cur_limit     = int'(LIMIT_RESET);
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_req_type   = REQ_ALLOC;
    in_slot_index = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Full map after reset: grants, mark, free of set and clear bits, clear all
    push_beat(REQ_ALLOC, '0);
    push_beat(REQ_ALLOC, '1);
    push_beat(REQ_MARK,  '0);
    push_beat(REQ_FREE,  '0);
    push_beat(REQ_FREE,  '0);
    push_beat(REQ_MARK,  '1);
    push_beat(REQ_FREE,  '1);
    push_beat(REQ_CLEAR, '1);
    // count stays at zero when a marked bit is freed
    push_beat(REQ_MARK,  IDX_W'(3));
    push_beat(REQ_FREE,  IDX_W'(3));
    push_beat(REQ_ALLOC, '0);

    // Limit below one byte: allocate always full, index range check
    settle_and_config(5);
    push_beat(REQ_ALLOC, '0);
    push_beat(REQ_MARK,  IDX_W'(4));
    push_beat(REQ_FREE,  IDX_W'(4));
    push_beat(REQ_MARK,  IDX_W'(5));

    // Partial last byte: bits 8..11 reachable by mark/free, never granted
    settle_and_config(12);
    push_beat(REQ_MARK,  IDX_W'(10));
    push_beat(REQ_FREE,  IDX_W'(10));
    repeat (8) push_beat(REQ_ALLOC, '0);

    // Random phases over several limits, first one without idling
    phase_limits = '{8192, 8, 64, 16383, 5, 100, 0, 0, 1001, 8};
    phase_limits[6] = $urandom_range(8, 300);
    phase_limits[7] = $urandom_range(8, 8192);
    foreach (phase_limits[p]) begin
      settle_and_config(phase_limits[p]);
      calm = (p == 0);
      repeat (PHASE_BEATS) random_beat();
    end
    calm = 1'b0;

    // Drain and let the block sit for a while
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_ctrl.sv
hdl/bba_datapath.sv
hdl/block_bitmap_allocator.sv
bench/block_bitmap_allocator_tb.sv
